/* hw/rtl/pstg_pkg.sv */
// Package: constants, register indexes and state type for the trail generator.
package pstg_pkg;

	localparam int unsigned DEF_MAX_POINTS    = 1024;
	localparam int unsigned DEF_MAX_SEGMENTS  = 64;
	localparam int unsigned DEF_TRAIL_SAMPLES = 32;

	localparam logic [8:0]  TAIL_PIXELS = 9'd300;
	localparam logic [16:0] ALPHA_BASE  = 17'd19661;
	localparam logic [15:0] ALPHA_SLOPE = 16'd45875;
	localparam int unsigned DIV_STEPS   = 25;

	typedef enum logic [1:0] {
		OP_POINT  = 2'd0,
		OP_ENERGY = 2'd1,
		OP_TICK   = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_SEGMENTS  = 2'd1,
		REG_POINTS    = 2'd2,
		REG_PERIMETER = 2'd3
	} reg_index_t;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_PEAK  = 10'b0000000010,
		ST_CHECK = 10'b0000000100,
		ST_DIV   = 10'b0000001000,
		ST_VMUL  = 10'b0000010000,
		ST_VPOS  = 10'b0000100000,
		ST_VADDR = 10'b0001000000,
		ST_VDATA = 10'b0010000000,
		ST_VPROD = 10'b0100000000,
		ST_VOUT  = 10'b1000000000
	} state_t;

endpackage

/* hw/rtl/perimeter_sweep_trail_generator_top.sv */
// Top level: trail generator with point and energy memories and vertex sequencer.
//
//  channel   dir  handshake          contents
//  s_*       in   s_tvalid/s_tready  opcode, entry, point, energy, time
//  m_*       out  m_tvalid/m_tready  vertex x/y, alpha, trail position, head, last
//  cfg_*     in   cfg_we             register index and data
//
// A point or energy write goes to its memory when the word is accepted. A tick
// runs the peak scan over segs energy entries and the 25-step tail divider, then
// steps each of 33 vertices through the multiply, position, address, data,
// product and output states, set by the point memory read and the interpolation
// multipliers. Reset clears all control state and the energy valid bits. Output
// stalls hold the sequencer at its output step; s_tready is high only while idle.
module perimeter_sweep_trail_generator_top
	import pstg_pkg::*;
#(
	parameter int unsigned MAX_POINTS    = DEF_MAX_POINTS,
	parameter int unsigned MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
	parameter int unsigned TRAIL_SAMPLES = DEF_TRAIL_SAMPLES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// entry_index, point_x, point_y, segment_energy, frame_time, zero pad
	input  logic [95:0] s_tdata,
	// opcode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// vertex_x, vertex_y, vertex_alpha, trail_position
	output logic [79:0] m_tdata,
	// is_head
	output logic        m_tuser,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [16:0] cfg_wdata
);

	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int VW = $clog2(TRAIL_SAMPLES + 1);
	localparam int unsigned ADIV = TRAIL_SAMPLES - 1;
	localparam int AW = $clog2(2 * TRAIL_SAMPLES);
	localparam int unsigned AQ = 65536 / ADIV;
	localparam int unsigned AR = 65536 % ADIV;

	state_t st_q;

	logic [15:0] thr_q;
	logic [6:0]  segcnt_q;
	logic [10:0] ptcnt_q;
	logic [16:0] perim_q;

	logic [31:0] pt_mem [MAX_POINTS];
	logic [15:0] en_mem [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] en_vld_q;

	logic [1:0]  in_op;
	logic [9:0]  in_idx;
	logic [15:0] in_x, in_y, in_e;
	logic [31:0] in_t;
	logic        in_acc;

	logic [10:0] segs;
	logic [16:0] idx17;
	logic        pt_we, en_we;

	logic [10:0] scnt_q;
	logic        pend_s1;
	logic [15:0] en_rd_s1;
	logic        en_vld_s1;
	logic [15:0] en_val;

	logic [15:0] scan_q, peak_q;
	logic [10:0] n_q;
	logic [16:0] gain_q;
	logic [32:0] gain_prod;

	logic [24:0] div_num_q, div_quo_q;
	logic [17:0] div_rem_q;
	logic [4:0]  div_cnt_q;
	logic [17:0] div_try;
	logic [16:0] div_perim;
	logic [16:0] tail_q;

	logic [VW-1:0] vcnt_q;
	logic [16:0]   along_q;
	logic [AW-1:0] arem_q;
	logic [AW:0]   arem_sum;
	logic          is_head;

	logic [33:0] off_prod, alpha_prod;
	logic [15:0] off_s1, alpha_s1;
	logic [15:0] pos;
	logic [26:0] k_s2;
	logic [10:0] nm1, i0, i1;
	logic [16:0] i0w, i1w;
	logic [31:0] p0_rd_s3, p1_rd_s3;
	logic signed [16:0] dx, dy, wsg;
	logic signed [33:0] px_s4, py_s4;
	logic [15:0] x0_s4, y0_s4;
	logic signed [34:0] sx, sy;
	logic [15:0] tpos;

	logic        out_free;
	logic [79:0] m_tdata_q;
	logic        m_tvalid_q, m_tuser_q;

	assign in_op  = s_tuser;
	assign in_idx = s_tdata[9:0];
	assign in_x   = s_tdata[25:10];
	assign in_y   = s_tdata[41:26];
	assign in_e   = s_tdata[57:42];
	assign in_t   = s_tdata[89:58];

	assign s_tready = (st_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	assign segs  = ({4'b0, segcnt_q} > 11'(MAX_SEGMENTS)) ? 11'(MAX_SEGMENTS) : {4'b0, segcnt_q};
	assign idx17 = {7'b0, in_idx};
	assign pt_we = in_acc && (in_op == OP_POINT) && (idx17 < 17'(MAX_POINTS));
	assign en_we = in_acc && (in_op == OP_ENERGY) && ({1'b0, in_idx} < segs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= '0;
			segcnt_q <= 7'd1;
			ptcnt_q  <= '0;
			perim_q  <= 17'd1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_THRESHOLD: thr_q    <= cfg_wdata[15:0];
				REG_SEGMENTS:  segcnt_q <= cfg_wdata[6:0];
				REG_POINTS:    ptcnt_q  <= cfg_wdata[10:0];
				REG_PERIMETER: perim_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamped point indexes for the current vertex
	assign nm1 = n_q - 11'd1;
	assign i0  = (k_s2[26:16] > nm1) ? nm1 : k_s2[26:16];
	assign i1  = (i0 + 11'd1 < n_q) ? i0 + 11'd1 : nm1;
	assign i0w = {6'b0, i0};
	assign i1w = {6'b0, i1};

	always_ff @(posedge clk) begin
		if (pt_we)
			pt_mem[idx17[PW-1:0]] <= {in_y, in_x};
		p0_rd_s3 <= pt_mem[i0w[PW-1:0]];
		p1_rd_s3 <= pt_mem[i1w[PW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (en_we)
			en_mem[in_idx[SW-1:0]] <= in_e;
		en_rd_s1 <= en_mem[scnt_q[SW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_vld_q  <= '0;
			en_vld_s1 <= 1'b0;
		end else begin
			if (en_we)
				en_vld_q[in_idx[SW-1:0]] <= 1'b1;
			en_vld_s1 <= en_vld_q[scnt_q[SW-1:0]];
		end
	end

	assign en_val = en_vld_s1 ? en_rd_s1 : 16'd0;

	assign gain_prod = {17'b0, peak_q} * {17'b0, ALPHA_SLOPE} + 33'd32768;
	assign div_perim = (perim_q == 17'd0) ? 17'd1 : perim_q;
	assign div_try   = {div_rem_q[16:0], div_num_q[24]};

	assign is_head  = (vcnt_q == VW'(TRAIL_SAMPLES));
	assign arem_sum = {1'b0, arem_q} + (AW+1)'(AR);
	assign off_prod   = {17'b0, tail_q} * {17'b0, 17'h10000 - along_q};
	assign alpha_prod = {17'b0, along_q} * {17'b0, gain_q} + 34'd32768;
	assign pos = is_head ? scan_q : scan_q - off_s1;

	assign wsg = $signed({1'b0, k_s2[15:0]});
	assign dx  = $signed({1'b0, p1_rd_s3[15:0]}) - $signed({1'b0, p0_rd_s3[15:0]});
	assign dy  = $signed({1'b0, p1_rd_s3[31:16]}) - $signed({1'b0, p0_rd_s3[31:16]});
	assign sx  = $signed({3'b0, x0_s4, 16'b0}) + 35'(px_s4) + 35'sd128;
	assign sy  = $signed({3'b0, y0_s4, 16'b0}) + 35'(py_s4) + 35'sd128;
	assign tpos = along_q[16] ? 16'hFFFF : along_q[15:0];

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			scnt_q     <= '0;
			pend_s1    <= 1'b0;
			div_cnt_q  <= '0;
			vcnt_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (st_q == ST_VOUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_acc && in_op == OP_TICK) begin
						scnt_q  <= '0;
						pend_s1 <= 1'b0;
						st_q    <= ST_PEAK;
					end
				end
				ST_PEAK: begin
					pend_s1 <= (scnt_q < segs);
					if (scnt_q < segs)
						scnt_q <= scnt_q + 11'd1;
					else if (!pend_s1)
						st_q <= ST_CHECK;
				end
				ST_CHECK: begin
					div_cnt_q <= '0;
					vcnt_q    <= '0;
					if (n_q < 11'd3 || peak_q < thr_q)
						st_q <= ST_IDLE;
					else
						st_q <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(DIV_STEPS - 1))
						st_q <= ST_VMUL;
				end
				ST_VMUL:  st_q <= ST_VPOS;
				ST_VPOS:  st_q <= ST_VADDR;
				ST_VADDR: st_q <= ST_VDATA;
				ST_VDATA: st_q <= ST_VPROD;
				ST_VPROD: st_q <= ST_VOUT;
				ST_VOUT: begin
					if (out_free) begin
						if (is_head) begin
							st_q <= ST_IDLE;
						end else begin
							vcnt_q <= vcnt_q + VW'(1);
							st_q   <= ST_VMUL;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				scan_q <= in_t[16:1];
				peak_q <= '0;
			end
			ST_PEAK: begin
				if (pend_s1 && en_val > peak_q)
					peak_q <= en_val;
				n_q <= ({6'b0, ptcnt_q} > 17'(MAX_POINTS)) ? 11'(MAX_POINTS) : ptcnt_q;
			end
			ST_CHECK: begin
				gain_q    <= ALPHA_BASE + gain_prod[32:16];
				div_num_q <= {9'b0, peak_q} * {16'b0, TAIL_PIXELS};
				div_rem_q <= '0;
				div_quo_q <= '0;
				along_q   <= '0;
				arem_q    <= '0;
			end
			ST_DIV: begin
				div_num_q <= {div_num_q[23:0], 1'b0};
				if (div_try >= {1'b0, div_perim}) begin
					div_rem_q <= div_try - {1'b0, div_perim};
					div_quo_q <= {div_quo_q[23:0], 1'b1};
				end else begin
					div_rem_q <= div_try;
					div_quo_q <= {div_quo_q[23:0], 1'b0};
				end
			end
			ST_VMUL: begin
				if (div_quo_q > 25'd65536)
					tail_q <= 17'h10000;
				else
					tail_q <= div_quo_q[16:0];
			end
			ST_VPOS: begin
				off_s1   <= off_prod[31:16];
				alpha_s1 <= (alpha_prod[33:16] > 18'd65535) ? 16'hFFFF : alpha_prod[31:16];
			end
			ST_VADDR: k_s2 <= {11'b0, pos} * {16'b0, nm1};
			ST_VDATA: ;
			ST_VPROD: begin
				px_s4 <= dx * wsg;
				py_s4 <= dy * wsg;
				x0_s4 <= p0_rd_s3[15:0];
				y0_s4 <= p0_rd_s3[31:16];
			end
			ST_VOUT: begin
				if (out_free) begin
					m_tdata_q <= is_head ? {32'hFFFF_FFFF, sy[31:8], sx[31:8]}
						: {tpos, alpha_s1, sy[31:8], sx[31:8]};
					m_tuser_q <= is_head;
					if (is_head) begin
					end else if (arem_sum >= (AW+1)'(ADIV)) begin
						along_q <= along_q + 17'(AQ) + 17'd1;
						arem_q  <= AW'(arem_sum - (AW+1)'(ADIV));
					end else begin
						along_q <= along_q + 17'(AQ);
						arem_q  <= arem_sum[AW-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tuser_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("state register not one-hot");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> div_cnt_q < 5'(DIV_STEPS))
		else $error("divider ran past its step count");

	a_addr_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_VDATA |-> (i0 < n_q && i1 < n_q))
		else $error("point index beyond point count");

	a_head_ends: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_VOUT && out_free && is_head |=> st_q == ST_IDLE && m_tvalid)
		else $error("head vertex did not close the run");

endmodule

/* sim/tb_perimeter_sweep_trail_generator_top.sv */
// Testbench: random and directed stream traffic against a trail predictor, field by field.
module tb_perimeter_sweep_trail_generator_top
	import pstg_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		opcode_t     op;
		logic [9:0]  idx;
		logic [15:0] px;
		logic [15:0] py;
		logic [15:0] en;
		logic [31:0] ft;
	} cmd_t;

	typedef struct packed {
		logic [23:0] vx;
		logic [23:0] vy;
		logic [15:0] alpha;
		logic [15:0] tpos;
		logic        head;
		logic        lst;
	} vertex_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [16:0] cfg_wdata;

	perimeter_sweep_trail_generator_top dut (.*);

	cmd_t        pending[$];
	cmd_t        cur;
	vertex_t     vertex_q[$];
	logic        s_fire;
	logic        hold;
	logic        idle_en;
	int          errors;
	int          trails;
	int          vertices;
	int          items_sent;

	logic [31:0] pts[1024];
	logic [15:0] energy[64];
	logic [15:0] thr;
	logic [6:0]  segcnt;
	logic [10:0] ptcnt;
	logic [16:0] perim;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic void lerp(input logic [15:0] p, input int unsigned n,
		output logic [23:0] xo, output logic [23:0] yo);
		logic [63:0] k, w, x0, y0, x1, y1;
		int unsigned i0, i1;
		k = 64'(p) * 64'(n - 1);
		i0 = 32'(k >> 16);
		w = k & 64'hFFFF;
		if (i0 > n - 1) i0 = n - 1;
		i1 = (i0 + 1 < n) ? i0 + 1 : n - 1;
		x0 = 64'(pts[i0][15:0]);
		y0 = 64'(pts[i0][31:16]);
		x1 = 64'(pts[i1][15:0]);
		y1 = 64'(pts[i1][31:16]);
		xo = 24'((x0 * (65536 - w) + x1 * w + 128) >> 8);
		yo = 24'((y0 * (65536 - w) + y1 * w + 128) >> 8);
	endfunction

	function automatic void trail_predict(input cmd_t c);
		int unsigned segs, n, pk, scan, tl, gain, pr, along, off;
		logic [63:0] a;
		vertex_t v;
		segs = (segcnt < 64) ? segcnt : 64;
		if (c.op == OP_POINT) begin
			pts[c.idx] = {c.py, c.px};
			return;
		end
		if (c.op == OP_ENERGY) begin
			if (c.idx < segs) energy[c.idx] = c.en;
			return;
		end
		if (c.op != OP_TICK) return;
		pk = 0;
		for (int i = 0; i < segs; i++) if (energy[i] > pk) pk = energy[i];
		n = (ptcnt < 1024) ? ptcnt : 1024;
		if (n < 3 || pk < thr) return;
		scan = (c.ft >> 1) & 32'hFFFF;
		pr = (perim != 0) ? perim : 1;
		tl = (pk * 300) / pr;
		if (tl > 65536) tl = 65536;
		gain = 19661 + 32'((64'(pk) * 45875 + 32768) >> 16);
		for (int i = 0; i < 32; i++) begin
			along = 32'((64'(i) * 65536) / 31);
			off = 32'((64'(tl) * (65536 - along)) >> 16);
			a = (64'(along) * gain + 32768) >> 16;
			lerp(16'(scan - off), n, v.vx, v.vy);
			v.alpha = (a > 65535) ? 16'hFFFF : 16'(a);
			v.tpos = (along > 65535) ? 16'hFFFF : 16'(along);
			v.head = 0;
			v.lst = 0;
			vertex_q = {vertex_q, v};
		end
		lerp(16'(scan), n, v.vx, v.vy);
		v.alpha = 16'hFFFF;
		v.tpos = 16'hFFFF;
		v.head = 1;
		v.lst = 1;
		vertex_q = {vertex_q, v};
		trails++;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (!(s_tvalid && !s_fire)) begin
				if (pending.size() != 0 && !hold && (!idle_en || $urandom_range(99) >= 22)) begin
					cur = pending.pop_front();
					s_tvalid <= 1;
					s_tuser <= cur.op;
					s_tdata <= {6'b0, cur.ft, cur.en, cur.py, cur.px, cur.idx};
				end else begin
					s_tvalid <= 0;
				end
			end
			m_tready <= !idle_en || $urandom_range(99) >= 22;
		end
	end

	always @(posedge clk) begin
		s_fire <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			trail_predict(cur);
			items_sent++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			vertex_t e;
			vertex_t g;
			g.vx = m_tdata[23:0];
			g.vy = m_tdata[47:24];
			g.alpha = m_tdata[63:48];
			g.tpos = m_tdata[79:64];
			g.head = m_tuser;
			g.lst = m_tlast;
			vertices++;
			if (vertex_q.size() == 0) begin
				$display("%t: unexpected word x=%h y=%h alpha=%h pos=%h head=%b last=%b",
					$time, g.vx, g.vy, g.alpha, g.tpos, g.head, g.lst);
				errors++;
			end else begin
				e = vertex_q.pop_front();
				if (g != e) begin
					$display("%t: mismatch exp x=%h y=%h alpha=%h pos=%h head=%b last=%b",
						$time, e.vx, e.vy, e.alpha, e.tpos, e.head, e.lst);
					$display("%t:          got x=%h y=%h alpha=%h pos=%h head=%b last=%b",
						$time, g.vx, g.vy, g.alpha, g.tpos, g.head, g.lst);
					errors++;
				end
			end
		end
	end

	task automatic push_cmd(input opcode_t op, input int idx, input int px, input int py,
		input int en, input logic [31:0] ft);
		cmd_t c;
		c.op = op;
		c.idx = 10'(idx);
		c.px = 16'(px);
		c.py = 16'(py);
		c.en = 16'(en);
		c.ft = ft;
		pending = {pending, c};
	endtask

	task automatic drain();
		do begin
			wait (pending.size() == 0 && !s_tvalid && vertex_q.size() == 0);
			repeat (400) @(negedge clk);
		end while (pending.size() != 0 || s_tvalid || vertex_q.size() != 0);
	endtask

	task automatic cfg_write(input reg_index_t r, input int val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_addr <= r;
		cfg_wdata <= 17'(val);
		case (r)
			REG_THRESHOLD: thr = 16'(val);
			REG_SEGMENTS:  segcnt = 7'(val);
			REG_POINTS:    ptcnt = 11'(val);
			default:       perim = 17'(val);
		endcase
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic rand_items(input int cnt, input int maxpt);
		int r;
		for (int i = 0; i < cnt; i++) begin
			r = $urandom_range(99);
			if (r < 40)
				push_cmd(OP_ENERGY, ($urandom_range(9) == 0) ? $urandom_range(1023)
					: $urandom_range(63), 0, 0, $urandom, $urandom);
			else if (r < 75)
				push_cmd(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
			else if (r < 90)
				push_cmd(OP_POINT, $urandom_range(maxpt), $urandom, $urandom, $urandom,
					$urandom);
			else
				push_cmd(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		int np;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = OP_NONE;
		m_tready = 0;
		cfg_we = 0;
		cfg_addr = REG_THRESHOLD;
		cfg_wdata = '0;
		s_fire = 0;
		hold = 0;
		idle_en = 1;
		errors = 0;
		trails = 0;
		vertices = 0;
		items_sent = 0;
		foreach (pts[i]) pts[i] = '0;
		foreach (energy[i]) energy[i] = '0;
		thr = 0;
		segcnt = 1;
		ptcnt = 0;
		perim = 1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		push_cmd(OP_TICK, 0, 0, 0, 0, 32'h7FFFFFFF);
		push_cmd(OP_NONE, 1023, 65535, 65535, 65535, 32'hFFFFFFFF);
		push_cmd(OP_POINT, 0, 0, 0, 0, 0);
		push_cmd(OP_POINT, 1, 65535, 65535, 0, 0);
		push_cmd(OP_POINT, 2, 65535, 0, 0, 0);
		push_cmd(OP_POINT, 3, 0, 65535, 0, 0);
		for (int i = 4; i < 8; i++) push_cmd(OP_POINT, i, $urandom, $urandom, 0, 0);
		push_cmd(OP_POINT, 1023, 65535, 65535, 0, 0);
		push_cmd(OP_ENERGY, 0, 0, 0, 65535, 0);
		push_cmd(OP_ENERGY, 1, 0, 0, 1234, 0);
		push_cmd(OP_ENERGY, 1023, 0, 0, 777, 0);
		drain();
		cfg_write(REG_POINTS, 2);
		push_cmd(OP_TICK, 0, 0, 0, 0, 32'h00010000);
		drain();
		cfg_write(REG_POINTS, 3);
		cfg_write(REG_PERIMETER, 0);
		push_cmd(OP_TICK, 0, 0, 0, 0, 32'h80000000);
		push_cmd(OP_TICK, 0, 0, 0, 0, 32'hFFFFFFFF);
		drain();
		cfg_write(REG_SEGMENTS, 0);
		cfg_write(REG_THRESHOLD, 1);
		push_cmd(OP_TICK, 0, 0, 0, 0, 32'h12345678);
		drain();
		cfg_write(REG_THRESHOLD, 0);
		push_cmd(OP_TICK, 0, 0, 0, 0, 32'h00000000);
		drain();
		cfg_write(REG_SEGMENTS, 64);
		cfg_write(REG_POINTS, 8);
		cfg_write(REG_PERIMETER, 131070);
		cfg_write(REG_THRESHOLD, 65535);
		push_cmd(OP_ENERGY, 63, 0, 0, 65535, 0);
		push_cmd(OP_TICK, 0, 0, 0, 0, $urandom);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			idle_en = (ph != 3 && ph != 4);
			np = $urandom_range(3, 8);
			cfg_write(REG_THRESHOLD, ($urandom_range(5) == 0) ? $urandom_range(65535)
				: $urandom_range(4000));
			cfg_write(REG_SEGMENTS, ($urandom_range(4) == 0) ? $urandom_range(127)
				: $urandom_range(1, 64));
			cfg_write(REG_POINTS, np);
			cfg_write(REG_PERIMETER, ($urandom_range(3) == 0) ? 131071
				: $urandom_range(1, 4000));
			rand_items(12, 7);
			wait (pending.size() <= 6);
			hold = 1;
			wait (vertex_q.size() == 0 && !s_tvalid);
			hold = 0;
			drain();
		end

		$display("Run covered %0d stream words, %0d trails and %0d vertex words,",
			items_sent, trails, vertices);
		$display("across point counts 2 to 8, all segment counts and perimeter extremes.");
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
